/* rtl/tlmc_pkg.sv */
`timescale 1ns / 1ps

package tlmc_pkg;

  // Default network sizes
  localparam int INPUT_COUNT_DEF  = 784;
  localparam int HIDDEN_COUNT_DEF = 16;
  localparam int CLASS_COUNT_DEF  = 10;

  // Request field widths
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 14;
  localparam int WEIGHT_W = 16;
  localparam int PIXEL_W = 8;

  // Result field widths
  localparam int CLS_W   = 4;
  localparam int SCORE_W = 60;

  // Datapath widths
  localparam int HID_W   = 40;                    // hidden sum, Q.12
  localparam int PROD1_W = WEIGHT_W + PIXEL_W + 1; // weight x pixel
  localparam int PROD2_W = HID_W + WEIGHT_W;       // hidden x weight
  localparam int ACC_W   = 64;                    // score accumulator

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_L1  = 2'd0,
    CMD_WR_L2  = 2'd1,
    CMD_PIXEL  = 2'd2,
    CMD_IGNORE = 2'd3
  } cmd_e;

endpackage

/* rtl/two_layer_mlp_classifier_top.sv */
// Two-layer linear perceptron with argmax. Requests are taken when start is
// high and busy is low. Weight writes (layer one or layer two) complete in the
// accepting cycle and keep busy low. A pixel request within the input count
// holds busy high while one shared multiply-accumulate walks the hidden
// units, so a new pixel is taken only after the last one is done. It reads
// one layer-one weight and one hidden sum per cycle from
// single-port-read memories, then drains the read/multiply/write-back pipeline.
// A pixel marked last additionally runs layer two, one multiply-accumulate per
// layer-two weight followed by a drain and compare,
// then drives valid_o for exactly one cycle with the winning class and score;
// busy stays high through that cycle. A last pixel that arrives after the
// input count is reached skips layer one and goes straight to layer two.
// The result is not held: the receiver must take it in that cycle. Hidden sums
// read as zero after reset and after each image through per-unit valid bits;
// no clearing pass is needed. Weights never written read as anything.
`timescale 1ns / 1ps

module two_layer_mlp_classifier_top #(
  parameter int INPUT_COUNT  = tlmc_pkg::INPUT_COUNT_DEF,
  parameter int HIDDEN_COUNT = tlmc_pkg::HIDDEN_COUNT_DEF,
  parameter int CLASS_COUNT  = tlmc_pkg::CLASS_COUNT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [tlmc_pkg::CMD_W-1:0]           cmd_i,
  input  logic [tlmc_pkg::INDEX_W-1:0]         weight_index_i,
  input  logic signed [tlmc_pkg::WEIGHT_W-1:0] weight_value_i,
  input  logic [tlmc_pkg::PIXEL_W-1:0]         pixel_value_i,
  input  logic                                 last_pixel_i,
  output logic                                 valid_o,
  output logic [tlmc_pkg::CLS_W-1:0]           class_index_o,
  output logic signed [tlmc_pkg::SCORE_W-1:0]  class_score_o
);
  import tlmc_pkg::*;

  localparam int FIRST_DEPTH  = INPUT_COUNT * HIDDEN_COUNT;
  localparam int SECOND_DEPTH = CLASS_COUNT * HIDDEN_COUNT;
  localparam int AW1 = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
  localparam int AW2 = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
  localparam int HW  = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
  localparam int PW  = $clog2(INPUT_COUNT + 1);

  // One-hot sequencer
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_L1   = 6'b000010,  // issue layer-one reads
    S_W1   = 6'b000100,  // drain layer-one write-back
    S_L2   = 6'b001000,  // issue layer-two reads
    S_W2   = 6'b010000,  // drain score pipeline
    S_OUT  = 6'b100000   // present result
  } state_e;

  // Tag that travels with each read through the pipeline
  typedef struct packed {
    logic             vld;
    logic             l2;     // layer-two operation
    logic             first;  // first hidden unit of a class
    logic             last;   // last hidden unit of a class
    logic             hv;     // hidden entry holds a written sum
    logic [HW-1:0]    h;
    logic [CLS_W-1:0] cls;
  } tag_t;

  state_e state_q, state_d;

  // Memories
  logic signed [WEIGHT_W-1:0] w1_mem  [FIRST_DEPTH];
  logic signed [WEIGHT_W-1:0] w2_mem  [SECOND_DEPTH];
  logic signed [HID_W-1:0]    hid_mem [HIDDEN_COUNT];
  logic signed [WEIGHT_W-1:0] w1_rd_q, w2_rd_q;
  logic signed [HID_W-1:0]    hid_rd_q;
  logic [HIDDEN_COUNT-1:0]    hv_q;

  // Sequencer counters
  logic [PW-1:0]    pos_q;
  logic [AW1-1:0]   a1_q;
  logic [AW2-1:0]   a2_q;
  logic [HW-1:0]    h_q;
  logic [CLS_W-1:0] c_q;
  logic [PIXEL_W-1:0] pix_q;
  logic             last_q;

  // Pipeline
  tag_t s1_q, s2_q, s3_q, s1_d, s3_d;
  logic signed [PROD1_W-1:0] p1_q;
  logic signed [HID_W-1:0]   hacc_q;
  logic signed [PROD2_W-1:0] p2_q;
  logic signed [ACC_W-1:0]   acc_q, asum;
  logic signed [ACC_W-1:0]   raw3_q;
  logic signed [HID_W:0]     hsum;
  logic signed [HID_W-1:0]   hsat, hid_mask;
  logic signed [SCORE_W-1:0] score3, best_s_q;
  logic [CLS_W-1:0]          best_c_q;

  logic accept, wr1, wr2, take_pix, issue, hid_we, pipe_empty;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign wr1 = accept && (cmd_i == CMD_WR_L1) && (32'(weight_index_i) < FIRST_DEPTH);
  assign wr2 = accept && (cmd_i == CMD_WR_L2) && (32'(weight_index_i) < SECOND_DEPTH);
  assign take_pix = accept && (cmd_i == CMD_PIXEL);
  assign issue  = (state_q == S_L1) || (state_q == S_L2);
  assign hid_we = s2_q.vld && !s2_q.l2;
  assign pipe_empty = !s1_q.vld && !s2_q.vld && !s3_q.vld;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (take_pix) begin
          if (32'(pos_q) < INPUT_COUNT) begin
            state_d = S_L1;
          end else if (last_pixel_i) begin
            state_d = S_L2;
          end
        end
      end
      S_L1: begin
        if (h_q == HW'(HIDDEN_COUNT - 1)) state_d = S_W1;
      end
      S_W1: begin
        if (pipe_empty) state_d = last_q ? S_L2 : S_IDLE;
      end
      S_L2: begin
        if (a2_q == AW2'(SECOND_DEPTH - 1)) state_d = S_W2;
      end
      S_W2: begin
        if (pipe_empty) state_d = S_OUT;
      end
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      hv_q    <= '0;
      h_q     <= '0;
      c_q     <= '0;
      a1_q    <= '0;
      a2_q    <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (take_pix) begin
            last_q <= last_pixel_i;
            h_q    <= '0;
            c_q    <= '0;
            a2_q   <= '0;
            a1_q   <= AW1'(pos_q);
            if (32'(pos_q) < INPUT_COUNT) pos_q <= pos_q + 1'b1;
          end
        end
        S_L1: begin
          h_q  <= h_q + 1'b1;
          a1_q <= a1_q + AW1'(INPUT_COUNT);
        end
        S_W1: begin
          h_q <= '0;
        end
        S_L2: begin
          a2_q <= a2_q + 1'b1;
          if (h_q == HW'(HIDDEN_COUNT - 1)) begin
            h_q <= '0;
            c_q <= c_q + 1'b1;
          end else begin
            h_q <= h_q + 1'b1;
          end
        end
        S_OUT: begin
          // image done: hidden sums read as zero again
          hv_q  <= '0;
          pos_q <= '0;
        end
        default: ;
      endcase
      if (hid_we) hv_q[s2_q.h] <= 1'b1;
    end
  end

  // Memory ports: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (wr1) w1_mem[AW1'(weight_index_i)] <= weight_value_i;
    w1_rd_q <= w1_mem[a1_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr2) w2_mem[AW2'(weight_index_i)] <= weight_value_i;
    w2_rd_q <= w2_mem[a2_q];
  end

  always_ff @(posedge clk_i) begin
    if (hid_we) hid_mem[s2_q.h] <= hsat;
    hid_rd_q <= hid_mem[h_q];
  end

  // Issue tag
  always_comb begin
    s1_d.vld   = issue;
    s1_d.l2    = (state_q == S_L2);
    s1_d.first = (h_q == '0);
    s1_d.last  = (h_q == HW'(HIDDEN_COUNT - 1));
    s1_d.hv    = hv_q[h_q];
    s1_d.h     = h_q;
    s1_d.cls   = c_q;
  end

  // only the last hidden unit of a class goes on to the compare stage
  always_comb begin
    s3_d     = s2_q;
    s3_d.vld = s2_q.vld && s2_q.l2 && s2_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      s3_q <= s3_d;
    end
  end

  // Stage 1: multiply
  assign hid_mask = s1_q.hv ? hid_rd_q : '0;

  always_ff @(posedge clk_i) begin
    p1_q   <= w1_rd_q * $signed({1'b0, pix_q});
    hacc_q <= hid_mask;
    p2_q   <= hid_mask * w2_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (take_pix) pix_q <= pixel_value_i;
  end

  // Stage 2: hidden write-back with saturation, or score accumulate
  assign hsum = (HID_W + 1)'(hacc_q) + (HID_W + 1)'(p1_q);
  always_comb begin
    if (hsum[HID_W] != hsum[HID_W-1]) begin
      hsat = hsum[HID_W] ? {1'b1, {(HID_W - 1){1'b0}}} : {1'b0, {(HID_W - 1){1'b1}}};
    end else begin
      hsat = hsum[HID_W-1:0];
    end
  end

  assign asum = (s2_q.first ? '0 : acc_q) + ACC_W'(p2_q);

  always_ff @(posedge clk_i) begin
    if (s2_q.vld && s2_q.l2) begin
      acc_q  <= asum;
      raw3_q <= asum;
    end
  end

  // Stage 3: clamp score and keep the first strict maximum
  always_comb begin
    if ((raw3_q[ACC_W-1:SCORE_W-1] != '0) && (raw3_q[ACC_W-1:SCORE_W-1] != '1)) begin
      score3 = raw3_q[ACC_W-1] ? {1'b1, {(SCORE_W - 1){1'b0}}}
                               : {1'b0, {(SCORE_W - 1){1'b1}}};
    end else begin
      score3 = raw3_q[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_pix) begin
      best_c_q <= '0;
      best_s_q <= '0;
    end else if (s3_q.vld && (score3 > best_s_q)) begin
      best_c_q <= s3_q.cls;
      best_s_q <= score3;
    end
  end

  assign valid_o       = (state_q == S_OUT);
  assign class_index_o = best_c_q;
  assign class_score_o = best_s_q;

  // Checks
  a_no_hid_write_in_l2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_L2) |-> !hid_we)
    else $error("hidden write-back overlaps layer-two reads");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> pipe_empty)
    else $error("pipeline busy while idle");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_pixel_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_pix && ((32'(pos_q) < INPUT_COUNT) || last_pixel_i)) |=> busy)
    else $error("pixel request did not start work");

endmodule
